// File: hdl/nqk_pkg.sv
// ----------------------------------------------------------------------------
// nqk_pkg
// microcode word, condition codes, datapath operations and the program rom
// ----------------------------------------------------------------------------
package nqk_pkg;

    // datapath operation selected by the control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLEAR,
        OP_TRY,
        OP_BACK,
        OP_COUNT,
        OP_EMIT,
        OP_EMIT_NF
    } op_t;

    // branch condition selected by the control word
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_TARGET_ZERO,
        C_CAN_TRY,
        C_FULL,
        C_COL_ZERO,
        C_HIT,
        C_EMIT_DONE,
        C_SLOT_FREE
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t S_IDLE    = 4'd0;
    localparam step_t S_START   = 4'd1;
    localparam step_t S_TRY     = 4'd2;
    localparam step_t S_DECIDE  = 4'd3;
    localparam step_t S_BACKCHK = 4'd4;
    localparam step_t S_BACK    = 4'd5;
    localparam step_t S_SOL     = 4'd6;
    localparam step_t S_EMIT    = 4'd7;
    localparam step_t S_NF      = 4'd8;

    // one control word: operation, condition, target when true, target when false
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jt;
        step_t jf;
    } uword_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic target_zero;
        logic can_try;
        logic full;
        logic col_zero;
        logic hit;
        logic emit_done;
        logic slot_free;
    } flags_t;

    // program rom
    function automatic uword_t ucode_fetch(step_t step);
        uword_t w;
        unique case (step)
            S_IDLE:    w = uword_t'{OP_ACCEPT,  C_IN_VALID,    S_START, S_IDLE};
            S_START:   w = uword_t'{OP_CLEAR,   C_TARGET_ZERO, S_NF,    S_TRY};
            S_TRY:     w = uword_t'{OP_TRY,     C_CAN_TRY,     S_TRY,   S_DECIDE};
            S_DECIDE:  w = uword_t'{OP_NONE,    C_FULL,        S_SOL,   S_BACKCHK};
            S_BACKCHK: w = uword_t'{OP_NONE,    C_COL_ZERO,    S_NF,    S_BACK};
            S_BACK:    w = uword_t'{OP_BACK,    C_ALWAYS,      S_TRY,   S_TRY};
            S_SOL:     w = uword_t'{OP_COUNT,   C_HIT,         S_EMIT,  S_BACK};
            S_EMIT:    w = uword_t'{OP_EMIT,    C_EMIT_DONE,   S_IDLE,  S_EMIT};
            S_NF:      w = uword_t'{OP_EMIT_NF, C_SLOT_FREE,   S_IDLE,  S_NF};
            default:   w = uword_t'{OP_NONE,    C_ALWAYS,      S_IDLE,  S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/nqk_if.sv
// ----------------------------------------------------------------------------
// nqk_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface nqk_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] solution_index;

    modport source (output valid, output solution_index, input ready);
    modport sink   (input valid, input solution_index, output ready);
endinterface

interface nqk_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] queen_column;
    logic [2:0] board_row;
    logic       found;
    logic       last;

    modport source (output valid, output queen_column, output board_row,
                    output found, output last, input ready);
    modport sink   (input valid, input queen_column, input board_row,
                    input found, input last, output ready);
endinterface

// File: hdl/nqk_sequencer.sv
// ----------------------------------------------------------------------------
// nqk_sequencer
// step counter, program rom fetch and conditional jump
// ----------------------------------------------------------------------------
module nqk_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  nqk_pkg::flags_t flags,
    output nqk_pkg::op_t    op,
    output nqk_pkg::step_t  step
);
    import nqk_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   take;

    always_comb
    begin
        uw = ucode_fetch(step_reg);
        unique case (uw.cond)
            C_ALWAYS:      take = 1'b1;
            C_IN_VALID:    take = flags.in_valid;
            C_TARGET_ZERO: take = flags.target_zero;
            C_CAN_TRY:     take = flags.can_try;
            C_FULL:        take = flags.full;
            C_COL_ZERO:    take = flags.col_zero;
            C_HIT:         take = flags.hit;
            C_EMIT_DONE:   take = flags.emit_done;
            C_SLOT_FREE:   take = flags.slot_free;
            default:       take = 1'b0;
        endcase
        step_next = take ? uw.jt : uw.jf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign op   = uw.op;
    assign step = step_reg;

endmodule

// File: hdl/nqk_datapath.sv
// ----------------------------------------------------------------------------
// nqk_datapath
// board state, one-row-per-cycle placement test, backtrack and result register
// ----------------------------------------------------------------------------
module nqk_datapath #(
    parameter int BOARD_SIZE = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  nqk_pkg::op_t    op,
    output nqk_pkg::flags_t flags,
    nqk_in_if.sink          req,
    nqk_out_if.source       rsp
);
    import nqk_pkg::*;

    localparam int N        = BOARD_SIZE;
    localparam int CW       = $clog2(N + 1);
    localparam int IW       = $clog2(N);
    localparam int DN       = 2 * N - 1;
    localparam int DW       = $clog2(DN);
    localparam int OUT_ROWS = (N < 8) ? N : 8;
    localparam int EW       = $clog2(OUT_ROWS);
    localparam int XW       = (IW > 3) ? IW : 3;

    logic [15:0]   target_reg, target_next;
    logic [15:0]   count_reg, count_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] r_reg, r_next;
    logic [IW-1:0] placed_reg [N];
    logic [IW-1:0] placed_next [N];
    logic [N-1:0]  rows_reg, rows_next;
    logic [DN-1:0] rise_reg, rise_next;
    logic [DN-1:0] fall_reg, fall_next;
    logic [EW-1:0] emit_reg, emit_next;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    qcol_reg, qcol_next;
    logic [2:0]    brow_reg, brow_next;
    logic          found_reg, found_next;
    logic          last_reg, last_next;
    logic          out_load;

    logic [CW-1:0] col_prev;
    logic [IW-1:0] col_prev_idx;
    logic [IW-1:0] back_row;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] col_idx;
    logic [DW-1:0] rise_idx;
    logic [DW-1:0] fall_idx;
    logic          cell_free;
    logic          slot_free;
    logic          can_try;
    logic          full;
    logic          emit_last;
    logic [IW-1:0] tog_row;
    logic [IW-1:0] tog_col;
    logic [N-1:0]  rows_tog;
    logic [DN-1:0] rise_tog;
    logic [DN-1:0] fall_tog;
    logic [XW-1:0] emit_col;

    // backtrack source: queen of the previous column
    assign col_prev     = col_reg - CW'(1);
    assign col_prev_idx = col_prev[IW-1:0];
    assign back_row     = placed_reg[col_prev_idx];

    // candidate cell of the current column
    assign r_idx    = r_reg[IW-1:0];
    assign col_idx  = col_reg[IW-1:0];
    assign rise_idx = DW'(r_reg) + DW'(col_reg);
    assign fall_idx = DW'(r_reg) + DW'(N - 1) - DW'(col_reg);

    assign full      = (col_reg == CW'(N));
    assign can_try   = !full && (r_reg != CW'(N));
    assign cell_free = can_try && !rows_reg[r_idx] && !rise_reg[rise_idx]
                       && !fall_reg[fall_idx];

    // shared toggle for placing and lifting a queen
    assign tog_row  = (op == OP_BACK) ? back_row : r_idx;
    assign tog_col  = (op == OP_BACK) ? col_prev_idx : col_idx;
    assign rows_tog = rows_reg ^ (N'(1) << tog_row);
    assign rise_tog = rise_reg ^ (DN'(1) << (DW'(tog_row) + DW'(tog_col)));
    assign fall_tog = fall_reg ^ (DN'(1) << (DW'(tog_row) + DW'(N - 1) - DW'(tog_col)));

    assign slot_free = !out_valid_reg || rsp.ready;
    assign emit_last = (emit_reg == EW'(OUT_ROWS - 1));

    // column of the queen in the row being emitted, last match wins
    always_comb
    begin
        emit_col = '0;
        for (int c = 0; c < N; c++)
        begin
            if (placed_reg[c] == IW'(emit_reg))
            begin
                emit_col = XW'(c);
            end
        end
    end

    always_comb
    begin
        target_next = target_reg;
        count_next  = count_reg;
        col_next    = col_reg;
        r_next      = r_reg;
        placed_next = placed_reg;
        rows_next   = rows_reg;
        rise_next   = rise_reg;
        fall_next   = fall_reg;
        emit_next   = emit_reg;
        out_load    = 1'b0;
        qcol_next   = qcol_reg;
        brow_next   = brow_reg;
        found_next  = found_reg;
        last_next   = last_reg;
        unique case (op)
            OP_ACCEPT:
            begin
                if (req.valid)
                begin
                    target_next = req.solution_index;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
                col_next   = '0;
                r_next     = '0;
                rows_next  = '0;
                rise_next  = '0;
                fall_next  = '0;
                emit_next  = '0;
                for (int c = 0; c < N; c++)
                begin
                    placed_next[c] = '0;
                end
            end
            OP_TRY:
            begin
                if (cell_free)
                begin
                    placed_next[col_idx] = r_idx;
                    rows_next = rows_tog;
                    rise_next = rise_tog;
                    fall_next = fall_tog;
                    col_next  = col_reg + CW'(1);
                    r_next    = '0;
                end
                else if (can_try)
                begin
                    r_next = r_reg + CW'(1);
                end
            end
            OP_BACK:
            begin
                col_next  = col_prev;
                rows_next = rows_tog;
                rise_next = rise_tog;
                fall_next = fall_tog;
                r_next    = CW'(back_row) + CW'(1);
            end
            OP_COUNT:
            begin
                count_next = count_reg + 16'd1;
            end
            OP_EMIT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    qcol_next  = emit_col[2:0];
                    brow_next  = 3'(emit_reg);
                    found_next = 1'b1;
                    last_next  = emit_last;
                    emit_next  = emit_reg + EW'(1);
                end
            end
            OP_EMIT_NF:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    qcol_next  = 3'd0;
                    brow_next  = 3'd0;
                    found_next = 1'b0;
                    last_next  = 1'b1;
                end
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            col_reg       <= '0;
            r_reg         <= '0;
            rows_reg      <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < N; c++)
            begin
                placed_reg[c] <= '0;
            end
        end
        else
        begin
            count_reg     <= count_next;
            col_reg       <= col_next;
            r_reg         <= r_next;
            rows_reg      <= rows_next;
            rise_reg      <= rise_next;
            fall_reg      <= fall_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            placed_reg    <= placed_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        qcol_reg   <= qcol_next;
        brow_reg   <= brow_next;
        found_reg  <= found_next;
        last_reg   <= last_next;
    end

    assign req.ready        = (op == OP_ACCEPT);
    assign rsp.valid        = out_valid_reg;
    assign rsp.queen_column = qcol_reg;
    assign rsp.board_row    = brow_reg;
    assign rsp.found        = found_reg;
    assign rsp.last         = last_reg;

    assign flags.in_valid    = req.valid;
    assign flags.target_zero = (target_reg == 16'd0);
    assign flags.can_try     = can_try;
    assign flags.full        = full;
    assign flags.col_zero    = (col_reg == '0);
    assign flags.hit         = ((count_reg + 16'd1) == target_reg);
    assign flags.emit_done   = slot_free && emit_last;
    assign flags.slot_free   = slot_free;

endmodule

// File: hdl/n_queens_kth_solution.sv
// ----------------------------------------------------------------------------
// n_queens_kth_solution: k-th solution of the n-queens puzzle, microcoded search
// search: each try step tests one row, each backtrack lifts the previous queen,
// then one result per cycle while the result channel is ready
// async active-low reset: sequencer to idle, board and counters empty
// ----------------------------------------------------------------------------
module n_queens_kth_solution #(
    parameter int BOARD_SIZE = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    nqk_in_if.sink    req,
    nqk_out_if.source rsp
);
    import nqk_pkg::*;

    // status from the datapath into the branch logic
    flags_t flags;
    // operation of the current control word
    op_t    op;
    // current program step
    step_t  step;

    // sequencer: fetches one control word a cycle from the program rom and
    // picks the next step from the selected condition
    nqk_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op),
        .step  (step)
    );

    // datapath: column-by-column placement with row, rising and falling
    // diagonal masks; each try step tests one row of the current column,
    // backtrack lifts the queen of the previous column and resumes one row
    // below it; the result register lets a new transaction be taken while
    // the final result still waits
    nqk_datapath #(
        .BOARD_SIZE (BOARD_SIZE)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .flags (flags),
        .req   (req),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    // requests are only taken in the idle step
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (step == S_IDLE))
        else $error("request taken outside idle step");

    // an accepted request starts a search
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (step == S_START))
        else $error("accepted request did not start a search");

    // a not-found result is a single cleared final result
    a_nf_single: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |->
            (rsp.last && rsp.queen_column == 3'd0 && rsp.board_row == 3'd0))
        else $error("malformed not-found result");

    // a found result before the final row is only taken while emission still runs
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && rsp.found && !rsp.last) |->
            (step == S_EMIT))
        else $error("emission left before the final row");
`endif

endmodule

// File: tb/sv/nqk_board_sb_pkg.sv
// ----------------------------------------------------------------------------
// nqk_board_sb_pkg
// board search predictor and result scoreboard for the k-th queens solver
// ----------------------------------------------------------------------------
package nqk_board_sb_pkg;

    localparam int BOARD_N  = 8;
    localparam int ROWS_OUT = (BOARD_N < 8) ? BOARD_N : 8;
    localparam int DIAG_N   = 2 * BOARD_N - 1;

    typedef struct packed {
        logic [2:0] queen_column;
        logic [2:0] board_row;
        logic       found;
        logic       last;
    } row_result_t;

    class queen_scoreboard;
        row_result_t        expected_rows[$];
        int                 errors;

        // own copy of the search state
        logic [3:0]         queen_row[BOARD_N];
        logic [3:0]         fill_col;
        logic [BOARD_N-1:0] rows_used;
        logic [DIAG_N-1:0]  rise_used;
        logic [DIAG_N-1:0]  fall_used;
        logic [15:0]        boards_counted;

        function new();
            errors = 0;
            clear_board();
            boards_counted = '0;
        endfunction

        function void clear_board();
            foreach (queen_row[c])
                queen_row[c] = '0;
            fill_col  = '0;
            rows_used = '0;
            rise_used = '0;
            fall_used = '0;
        endfunction

        function void flip_queen(int r, int c);
            rows_used[r]                 ^= 1'b1;
            rise_used[r + c]             ^= 1'b1;
            fall_used[r + BOARD_N - 1 - c] ^= 1'b1;
        endfunction

        // backtracking search, leaves the board of the wanted rank in place
        function bit place_to_rank(logic [15:0] rank);
            int r;
            int first_row;
            bit retreat;
            clear_board();
            boards_counted = '0;
            first_row = 0;
            while (1'b1) begin
                if (fill_col == BOARD_N) begin
                    boards_counted = boards_counted + 16'd1;
                    if (boards_counted == rank)
                        return 1'b1;
                    retreat = 1'b1;
                end
                else begin
                    for (r = first_row; r < BOARD_N; r++)
                        if (!rows_used[r] && !rise_used[r + fill_col]
                            && !fall_used[r + BOARD_N - 1 - fill_col])
                            break;
                    if (r < BOARD_N) begin
                        queen_row[fill_col] = r[3:0];
                        flip_queen(r, fill_col);
                        fill_col = fill_col + 4'd1;
                        first_row = 0;
                        retreat = 1'b0;
                    end
                    else if (fill_col == 0) begin
                        return 1'b0;
                    end
                    else begin
                        retreat = 1'b1;
                    end
                end
                if (retreat) begin
                    fill_col = fill_col - 4'd1;
                    flip_queen(queen_row[fill_col], fill_col);
                    first_row = queen_row[fill_col] + 1;
                end
            end
            return 1'b0;
        endfunction

        // accepted request: queue the rows that it must produce
        function void note_request(logic [15:0] index);
            row_result_t item;
            logic [2:0]  col;
            if (index == 16'd0 || !place_to_rank(index)) begin
                item = '{queen_column: 3'd0, board_row: 3'd0, found: 1'b0, last: 1'b1};
                expected_rows.push_back(item);
                return;
            end
            for (int r = 0; r < ROWS_OUT; r++) begin
                col = 3'd0;
                for (int c = 0; c < BOARD_N; c++)
                    if (queen_row[c] == r)
                        col = c[2:0];
                item.queen_column = col;
                item.board_row    = r[2:0];
                item.found        = 1'b1;
                item.last         = (r == ROWS_OUT - 1);
                expected_rows.push_back(item);
            end
        endfunction

        function void compare_field(string name, int want, int got, realtime stamp);
            if (want !== got) begin
                $display("%0.3f ns: %s mismatch, expected %0d, actual %0d",
                         stamp, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] queen_column, logic [2:0] board_row,
                                   logic found, logic last, realtime stamp);
            row_result_t want;
            if (expected_rows.size() == 0) begin
                $display("%0.3f ns: unexpected result, expected none, actual %0d/%0d/%0b/%0b",
                         stamp, queen_column, board_row, found, last);
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            compare_field("queen_column", want.queen_column, queen_column, stamp);
            compare_field("board_row", want.board_row, board_row, stamp);
            compare_field("found", want.found, found, stamp);
            compare_field("last", want.last, last, stamp);
        endfunction
    endclass

endpackage

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives solution ranks into the queens solver and checks every row that it
// returns against a backtracking predictor, with random gaps on both channels
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nqk_board_sb_pkg::*;

    // quiet cycles allowed before the watchdog ends the run
    localparam int WATCHDOG_LIMIT = 200000;
    // results come one per cycle while ready is high, so a short tail catches strays
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 100;
    // solution count of the 8x8 board, used only to shape the stimulus
    localparam int SOLUTION_TOTAL = 92;

    // extremes, first and last solutions, just past the count, bit patterns
    localparam logic [15:0] DIRECTED_LIST [18] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd46, 16'd91, 16'd92, 16'd93,
        16'd94, 16'h00FF, 16'h0100, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000,
        16'hFFFE, 16'hFFFF
    };

    logic clk;
    logic rst_n;

    nqk_in_if  req_ch ();
    nqk_out_if rsp_ch ();

    n_queens_kth_solution #(
        .BOARD_SIZE(BOARD_N)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    queen_scoreboard sb;

    // when set, neither side inserts idle cycles
    bit no_idle;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // idle cycles before the next transaction on either channel
    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    // mostly ranks that exist, some past the count, some zero, some any pattern
    function automatic logic [15:0] pick_index();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            return 16'($urandom_range(1, SOLUTION_TOTAL));
        else if (sel < 88)
            return 16'($urandom_range(SOLUTION_TOTAL + 1, 65535));
        else if (sel < 93)
            return 16'd0;
        else
            return 16'($urandom);
    endfunction

    // one request transaction; valid stays high when no gap is drawn
    task automatic send_index(input logic [15:0] index);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.solution_index <= index;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(index);
    endtask

    // one result transaction, with a random stall before ready goes high
    task automatic take_result();
        int stall;
        stall = draw_gap();
        if (stall > 0)
        begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        rsp_ch.ready <= 1'b1;
        do
            @(posedge clk);
        while (!rsp_ch.valid);
        sb.check_result(rsp_ch.queen_column, rsp_ch.board_row, rsp_ch.found,
                        rsp_ch.last, $realtime);
    endtask

    // result side runs for the whole simulation
    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever take_result();
    end

    // ends the run when no transaction moves on either channel for too long
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        sb      = new();
        no_idle = 1'b0;
        rst_n   = 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.solution_index <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ranks
        foreach (DIRECTED_LIST[i])
            send_index(DIRECTED_LIST[i]);

        // random ranks, with a back-to-back stretch in the middle
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 40 && i < 60);
            send_index(pick_index());
        end
        no_idle = 1'b0;
        req_ch.valid <= 1'b0;

        // let every queued row arrive, then watch for extra results
        while (sb.expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
hdl/nqk_pkg.sv
hdl/nqk_if.sv
hdl/nqk_sequencer.sv
hdl/nqk_datapath.sv
hdl/n_queens_kth_solution.sv
tb/sv/nqk_board_sb_pkg.sv
tb/sv/tb_top.sv
